@@ hdl/pidpc_pkg.sv @@
package pidpc_pkg;

    localparam int POS_W    = 24;
    localparam int GAIN_W   = 16;
    localparam int TOL_W    = 16;
    localparam int TICK_W   = 16;
    localparam int SPEED_W  = 8;
    localparam int ERR_W    = 25;
    localparam int DERR_W   = 26;
    localparam int SUM_W    = 40;
    localparam int SUM_X_W  = SUM_W + 1;
    localparam int CFG_IDX_W = 3;

    // serial product: wide enough for the exact sum of the three terms
    localparam int PROD_W   = 58;
    localparam int ACC_W    = 20;

    // drive measurement: floor((5*(L+R) + 9) / 18), biased to stay non-negative
    localparam int DIV_W     = 29;
    localparam int DIV_REM_W = 5;
    localparam logic [DIV_REM_W:0] DIV_CONST = 6'd18;
    localparam logic [DIV_W-1:0]   DIV_BIAS  = 29'd150994944;
    localparam logic [DIV_W-1:0]   DIV_ROUND = 29'd9;
    localparam logic [ERR_W-1:0]   MEAS_BIAS = 25'd8388608;

    localparam logic signed [SPEED_W-1:0] SPEED_LIM = 8'sd100;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } pidpc_op_t;

    typedef enum logic {
        MODE_DRIVE = 1'b0,
        MODE_TURN  = 1'b1
    } pidpc_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE      = 3'd0,
        CFG_GAIN_P    = 3'd1,
        CFG_GAIN_I    = 3'd2,
        CFG_GAIN_D    = 3'd3,
        CFG_TOLERANCE = 3'd4,
        CFG_MAX_TICKS = 3'd5
    } pidpc_cfg_idx_t;

    typedef struct packed {
        logic                    op;
        logic signed [POS_W-1:0] target;
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_position;
        logic signed [POS_W-1:0] heading;
    } pidpc_in_t;

    typedef struct packed {
        logic signed [SPEED_W-1:0] left_speed;
        logic signed [SPEED_W-1:0] right_speed;
        logic                      done_res;
        logic                      timed_out;
        logic                      running;
    } pidpc_out_t;

endpackage

@@ hdl/pidpc_div18.sv @@
module pidpc_div18 (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [pidpc_pkg::DIV_W-1:0] dividend,
    output logic                        done,
    output logic [pidpc_pkg::DIV_W-1:0] quotient
);
    import pidpc_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);

    logic [DIV_W-1:0]     work_reg;
    logic [DIV_REM_W-1:0] rem_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [DIV_REM_W:0]   trial;
    logic                 fits;

    // restoring division, one quotient bit a cycle, MSB first
    assign trial = {rem_reg, work_reg[DIV_W-1]};
    assign fits  = (trial >= DIV_CONST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(DIV_W - 1));
            if (start) begin
                work_reg <= dividend;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= fits ? DIV_REM_W'(trial - DIV_CONST) : trial[DIV_REM_W-1:0];
                // quotient bits fill in behind the outgoing dividend bits
                work_reg <= {work_reg[DIV_W-2:0], fits};
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

@@ hdl/pidpc_smac.sv @@
module pidpc_smac #(
    parameter int RND_POS = 15
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [pidpc_pkg::GAIN_W-1:0] gain_p,
    input  logic signed [pidpc_pkg::GAIN_W-1:0] gain_i,
    input  logic signed [pidpc_pkg::GAIN_W-1:0] gain_d,
    input  logic signed [pidpc_pkg::ERR_W-1:0]  err,
    input  logic signed [pidpc_pkg::SUM_W-1:0]  err_sum,
    input  logic signed [pidpc_pkg::DERR_W-1:0] err_diff,
    output logic                                done,
    output logic signed [pidpc_pkg::PROD_W-1:0] product
);
    import pidpc_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    logic signed [ERR_W-1:0]  e_sr;
    logic signed [SUM_W-1:0]  s_sr;
    logic signed [DERR_W-1:0] d_sr;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [PROD_W-1:0]        prod_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     busy_reg;
    logic                     done_reg;

    logic signed [ACC_W-1:0]  pp_p;
    logic signed [ACC_W-1:0]  pp_i;
    logic signed [ACC_W-1:0]  pp_d;
    logic [ACC_W-1:0]         rnd;
    logic signed [ACC_W-1:0]  acc_sum;

    // operands go in LSB first, sign-extended; gains stay parallel
    assign pp_p = e_sr[0] ? ACC_W'(gain_p) : '0;
    assign pp_i = s_sr[0] ? ACC_W'(gain_i) : '0;
    assign pp_d = d_sr[0] ? ACC_W'(gain_d) : '0;
    // half an output LSB, added at the bit just below the kept part
    assign rnd  = {{(ACC_W-1){1'b0}}, (cnt_reg == CNT_W'(RND_POS))};
    assign acc_sum = acc_reg + pp_p + pp_i + pp_d + rnd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !start && (cnt_reg == CNT_W'(PROD_W - 1));
            if (start) begin
                e_sr     <= err;
                s_sr     <= err_sum;
                d_sr     <= err_diff;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                e_sr     <= e_sr >>> 1;
                s_sr     <= s_sr >>> 1;
                d_sr     <= d_sr >>> 1;
                prod_reg <= {acc_sum[0], prod_reg[PROD_W-1:1]};
                acc_reg  <= acc_sum >>> 1;
                cnt_reg  <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(PROD_W - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = prod_reg;

endmodule

@@ hdl/pid_position_controller_unit.sv @@
// Channel  Direction  Handshake          Payload
// s_       in         s_valid/s_ready    s_data  (pidpc_in_t: op, target, positions, heading)
// m_       out        m_valid/m_ready    m_data  (pidpc_out_t: speeds, done_res, timed_out, running)
// cfg_     in         cfg_valid/cfg_ready cfg_index, cfg_data (register write, always ready)
//
// One item at a time. A start, an idle tick or a timed-out tick goes straight from idle to
// the emit state; a tick that ends inside the tolerance passes the error state, in drive
// mode after the divide. A computing tick in turn mode runs the 58-step bit-serial
// multiply-accumulate after the error state; in drive mode the 29-step divide by 18 runs first.
// Reset is synchronous on aresetn low: control and configuration registers return to their defaults, move idle.
// A result waits in the output register while the next item is already taken in; a second
// result holds in the emit state, and the input stalls, until m_ready frees the register.
module pid_position_controller_unit #(
    parameter int FRAC_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  pidpc_pkg::pidpc_in_t               s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output pidpc_pkg::pidpc_out_t              m_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [pidpc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pidpc_pkg::GAIN_W-1:0]       cfg_data
);
    import pidpc_pkg::*;

    localparam int SHIFT = 8 + FRAC_BITS;
    localparam logic signed [31:0] WRAP_LIM = 32'sd180 <<< FRAC_BITS;
    localparam logic signed [31:0] WRAP_SUB = 32'sd360 <<< FRAC_BITS;

    // stopped speeds, then done_res, timed_out, running
    localparam pidpc_out_t RES_IDLE    = {{(2*SPEED_W){1'b0}}, 1'b0, 1'b0, 1'b0};
    localparam pidpc_out_t RES_START   = {{(2*SPEED_W){1'b0}}, 1'b0, 1'b0, 1'b1};
    localparam pidpc_out_t RES_DONE    = {{(2*SPEED_W){1'b0}}, 1'b1, 1'b0, 1'b0};
    localparam pidpc_out_t RES_TIMEOUT = {{(2*SPEED_W){1'b0}}, 1'b0, 1'b1, 1'b0};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_ERR,
        ST_MAC,
        ST_EMIT
    } state_t;

    state_t                    state_reg;

    logic                      mode_reg;
    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic [TOL_W-1:0]          tol_reg;
    logic [TICK_W-1:0]         max_ticks_reg;

    logic signed [POS_W-1:0]   target_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [ERR_W-1:0]   last_err_reg;
    logic [TICK_W-1:0]         ticks_reg;
    logic                      active_reg;

    logic signed [ERR_W-1:0]   meas_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DERR_W-1:0]  de_reg;
    logic                      mac_start_reg;
    pidpc_out_t                res_reg;
    pidpc_out_t                m_data_reg;
    logic                      m_valid_reg;

    logic                      s_take;
    logic                      tick_go;
    logic signed [31:0]        tgt_ext;
    logic signed [POS_W-1:0]   tgt_start;
    logic signed [DIV_W-1:0]   pos_sum;
    logic [DIV_W-1:0]          dividend;
    logic                      div_done;
    logic [DIV_W-1:0]          quotient;

    logic signed [ERR_W-1:0]   e_val;
    logic [ERR_W-1:0]          e_mag;
    logic                      in_band;
    logic signed [SUM_X_W-1:0] sum_wide;
    logic signed [SUM_W-1:0]   sum_sat;
    logic signed [DERR_W-1:0]  de_val;

    logic                      mac_done;
    logic signed [PROD_W-1:0]  mac_prod;
    logic signed [PROD_W-1:0]  prod_shr;
    logic signed [SPEED_W-1:0] speed_val;
    logic signed [SPEED_W-1:0] right_val;
    logic                      emit_go;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_take    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // a tick that goes on to measure and compute
    assign tick_go = s_take && (s_data.op == OP_TICK) && active_reg
                     && (ticks_reg < max_ticks_reg);

    assign tgt_ext   = 32'(s_data.target);
    assign tgt_start = (mode_reg == MODE_TURN && tgt_ext > WRAP_LIM) ?
                       POS_W'(tgt_ext - WRAP_SUB) : s_data.target;

    assign pos_sum  = DIV_W'(s_data.left_position) + DIV_W'(s_data.right_position);
    assign dividend = DIV_W'(pos_sum <<< 2) + DIV_W'(pos_sum) + DIV_ROUND + DIV_BIAS;

    pidpc_div18 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (tick_go && (mode_reg == MODE_DRIVE)),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    assign e_val    = ERR_W'(target_reg) - meas_reg;
    assign e_mag    = e_val[ERR_W-1] ? ERR_W'(-e_val) : ERR_W'(e_val);
    assign in_band  = (e_mag <= ERR_W'(tol_reg));
    assign sum_wide = SUM_X_W'(sum_reg) + SUM_X_W'(e_val);
    assign sum_sat  = (sum_wide[SUM_W] == sum_wide[SUM_W-1]) ? sum_wide[SUM_W-1:0] :
                      sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} :
                                        {1'b0, {(SUM_W-1){1'b1}}};
    assign de_val   = DERR_W'(e_val) - DERR_W'(last_err_reg);

    pidpc_smac #(
        .RND_POS (SHIFT - 1)
    ) u_mac (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (mac_start_reg),
        .gain_p   (gain_p_reg),
        .gain_i   (gain_i_reg),
        .gain_d   (gain_d_reg),
        .err      (err_reg),
        .err_sum  (sum_reg),
        .err_diff (de_reg),
        .done     (mac_done),
        .product  (mac_prod)
    );

    // rounding is already in the product: drop the fraction and clamp
    assign prod_shr  = mac_prod >>> SHIFT;
    assign speed_val = (prod_shr > PROD_W'(SPEED_LIM))  ? SPEED_LIM :
                       (prod_shr < -PROD_W'(SPEED_LIM)) ? -SPEED_LIM :
                       prod_shr[SPEED_W-1:0];
    assign right_val = (mode_reg == MODE_TURN) ? -speed_val : speed_val;

    // hold until the output register is free or being emptied
    assign emit_go = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_DRIVE;
            gain_p_reg    <= 16'sd256;
            gain_i_reg    <= '0;
            gain_d_reg    <= '0;
            tol_reg       <= 16'd26;
            max_ticks_reg <= 16'd250;
        end else if (cfg_valid && cfg_ready) begin
            case (pidpc_cfg_idx_t'(cfg_index))
                CFG_MODE:      mode_reg      <= cfg_data[0];
                CFG_GAIN_P:    gain_p_reg    <= cfg_data;
                CFG_GAIN_I:    gain_i_reg    <= cfg_data;
                CFG_GAIN_D:    gain_d_reg    <= cfg_data;
                CFG_TOLERANCE: tol_reg       <= cfg_data;
                CFG_MAX_TICKS: max_ticks_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            target_reg    <= '0;
            sum_reg       <= '0;
            last_err_reg  <= '0;
            ticks_reg     <= '0;
            active_reg    <= 1'b0;
            mac_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            mac_start_reg <= (state_reg == ST_ERR) && !in_band;
            if (emit_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_take) begin
                        if (s_data.op == OP_START) begin
                            target_reg   <= tgt_start;
                            sum_reg      <= '0;
                            last_err_reg <= '0;
                            ticks_reg    <= '0;
                            active_reg   <= 1'b1;
                            res_reg      <= RES_START;
                            state_reg    <= ST_EMIT;
                        end else if (!active_reg) begin
                            res_reg   <= RES_IDLE;
                            state_reg <= ST_EMIT;
                        end else if (ticks_reg >= max_ticks_reg) begin
                            active_reg <= 1'b0;
                            res_reg    <= RES_TIMEOUT;
                            state_reg  <= ST_EMIT;
                        end else if (mode_reg == MODE_DRIVE) begin
                            state_reg <= ST_DIV;
                        end else begin
                            meas_reg  <= ERR_W'(s_data.heading);
                            state_reg <= ST_ERR;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        meas_reg  <= ERR_W'(quotient) - MEAS_BIAS;
                        state_reg <= ST_ERR;
                    end
                end
                ST_ERR: begin
                    if (in_band) begin
                        active_reg <= 1'b0;
                        res_reg    <= RES_DONE;
                        state_reg  <= ST_EMIT;
                    end else begin
                        sum_reg   <= sum_sat;
                        err_reg   <= e_val;
                        de_reg    <= de_val;
                        state_reg <= ST_MAC;
                    end
                end
                ST_MAC: begin
                    if (mac_done) begin
                        last_err_reg <= err_reg;
                        ticks_reg    <= ticks_reg + 1'b1;
                        res_reg      <= {speed_val, right_val, 1'b0, 1'b0, 1'b1};
                        state_reg    <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (emit_go) begin
                        m_data_reg <= res_reg;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    a_div_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside its wait state");

    a_mac_in_state: assert property (@(posedge aclk) disable iff (!aresetn)
        mac_done |-> state_reg == ST_MAC)
        else $error("multiply-accumulate finished outside its wait state");

    a_finish_not_running: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.running |-> !m_data_reg.done_res && !m_data_reg.timed_out)
        else $error("finished move still flagged as running");

    a_stopped_speeds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_data_reg.running |->
            m_data_reg.left_speed == '0 && m_data_reg.right_speed == '0)
        else $error("stopped move with non-zero wheel speed");

    a_speed_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_data_reg.left_speed <= SPEED_LIM
                        && m_data_reg.left_speed >= -SPEED_LIM)
        else $error("wheel speed outside saturation range");

endmodule
